// ===== rtl/text_escape_sequence_parser_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TEXT_ESCAPE_SEQUENCE_PARSER_UNIT_ASSERT_SVH
`define TEXT_ESCAPE_SEQUENCE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define TESP_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tesp: same-cycle property failed");

// Next-cycle implication, inactive while reset is asserted.
`define TESP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tesp: next-cycle property failed");

`endif

// ===== rtl/tesp_pkg.sv =====
package tesp_pkg;

  // Field widths
  localparam int unsigned CODE_W     = 16;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned SPAN_W     = 9;
  localparam int unsigned EXT_LEN_W  = 4;
  localparam int unsigned NAME_CNT_W = 8;

  // Parameter defaults
  localparam int unsigned NAME_CHARS_DEF   = 4;
  localparam int unsigned EXTENDED_MAX_DEF = 15;

  // Extended characters that feed the colour
  localparam int unsigned COLOUR_CHARS = 6;

  // Special characters
  localparam logic [CODE_W-1:0] CLOSE_BRACE = 16'h007D;
  localparam logic [CODE_W-1:0] COLON_CHAR  = 16'h003A;
  localparam logic [CODE_W-1:0] ALPHA_MARK  = 16'h0070;

  localparam logic [CHAN_W-1:0]     ALPHA_OPAQUE   = 8'hFF;
  localparam logic [NAME_CNT_W-1:0] NAME_COUNT_MAX = 8'hFF;

  // Kind codes
  typedef enum logic [KIND_W-1:0] {
    KIND_EMPTY   = 3'd0,
    KIND_BRACE   = 3'd1,
    KIND_NBS     = 3'd2,
    KIND_CLR     = 3'd3,
    KIND_P       = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_e;

  // Known names, big-endian packed, indexed by kind code
  localparam int unsigned KEY_COUNT = 5;
  localparam logic [31:0] NAME_KEYS [KEY_COUNT] = '{
    32'h0000_0000, 32'h7B00_0000, 32'h6E62_7300, 32'h636C_7200, 32'h7000_0000
  };

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [CHAN_W-1:0]    alpha;
    logic [SPAN_W-1:0]    span;
    logic [EXT_LEN_W-1:0] extended_length;
    logic                 has_extended;
  } result_t;

  // Hex digit value, MSB set when the character is a digit
  function automatic logic [4:0] hex_digit(input logic [CODE_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, 4'(c - 16'h0030)};
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      r = {1'b1, 4'(c - 16'h0061 + 16'd10)};
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      r = {1'b1, 4'(c - 16'h0041 + 16'd10)};
    end
    return r;
  endfunction

  // Two-digit channel; a bad second digit leaves the first digit alone
  function automatic logic [CHAN_W-1:0] hex_pair(input logic [CODE_W-1:0] a,
                                                 input logic [CODE_W-1:0] b);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [CHAN_W-1:0] r;
    hi = hex_digit(a);
    lo = hex_digit(b);
    if (!hi[4]) begin
      r = '0;
    end else if (!lo[4]) begin
      r = {4'd0, hi[3:0]};
    end else begin
      r = {hi[3:0], lo[3:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/tesp_if.sv =====
// Code unit channel
interface tesp_in_if;
  import tesp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

// Result channel
interface tesp_out_if;
  import tesp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic [CHAN_W-1:0]    alpha;
  logic [SPAN_W-1:0]    span;
  logic [EXT_LEN_W-1:0] extended_length;
  logic                 has_extended;

  modport source (output valid, output kind, output red, output green, output blue,
                  output alpha, output span, output extended_length,
                  output has_extended, input ready);
  modport sink   (input valid, input kind, input red, input green, input blue,
                  input alpha, input span, input extended_length,
                  input has_extended, output ready);
endinterface

// ===== rtl/tesp_decode.sv =====
// Build one result from the collected sequence state.
module tesp_decode #(
  parameter int unsigned NAME_CHARS = tesp_pkg::NAME_CHARS_DEF,
  parameter int unsigned ECW        = 4
) (
  input  logic [7:0]                       name_bytes_i [NAME_CHARS],
  input  logic [tesp_pkg::NAME_CNT_W-1:0]  name_count_i,
  input  logic [tesp_pkg::CODE_W-1:0]      ext_chars_i [tesp_pkg::COLOUR_CHARS],
  input  logic [ECW-1:0]                   ext_count_i,
  input  logic                             has_ext_i,
  output tesp_pkg::result_t                result_o
);
  import tesp_pkg::*;

  logic [63:0]       key;
  logic [KIND_W-1:0] kind;
  logic [SPAN_W-1:0] ext_span;

  // Pack the name big-endian; bytes past the name width stay zero
  always_comb begin
    key = '0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      key[63-8*i -: 8] = name_bytes_i[i];
    end
  end

  // Match against the known names, lowest index wins
  always_comb begin
    kind = KIND_UNKNOWN;
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      if (key == {NAME_KEYS[k], 32'h0000_0000}) begin
        kind = KIND_W'(k);
      end
    end
  end

  // Extended part adds its characters plus the colon
  assign ext_span = has_ext_i ? (SPAN_W'(ext_count_i) + SPAN_W'(1)) : '0;

  // Colour, span and length
  always_comb begin
    result_o.kind = kind;
    if (ext_chars_i[0] == ALPHA_MARK) begin
      result_o.red   = '0;
      result_o.green = '0;
      result_o.blue  = '0;
      result_o.alpha = '0;
    end else begin
      result_o.red   = hex_pair(ext_chars_i[0], ext_chars_i[1]);
      result_o.green = hex_pair(ext_chars_i[2], ext_chars_i[3]);
      result_o.blue  = hex_pair(ext_chars_i[4], ext_chars_i[5]);
      result_o.alpha = ALPHA_OPAQUE;
    end
    result_o.span            = SPAN_W'(name_count_i) + SPAN_W'(2) + ext_span;
    result_o.extended_length = EXT_LEN_W'(ext_count_i);
    result_o.has_extended    = has_ext_i;
  end

endmodule

// ===== rtl/text_escape_sequence_parser_unit.sv =====
// Channel  Dir  Port   Payload
// -------  ---  -----  ----------------------------------------------------------
// input    in   src_i  code_unit[15:0]
// result   out  res_o  kind, red, green, blue, alpha, span, extended_length,
//                      has_extended
//
// One code unit is taken per cycle; a terminating unit loads the result register
// and the result is offered on the next cycle.
// Throughput is set by the single result register: input stalls only while a
// result is held and res_o.ready is low.
// Asynchronous active-low reset clears all sequence state and the result valid.
module text_escape_sequence_parser_unit #(
  parameter int unsigned NAME_CHARS   = tesp_pkg::NAME_CHARS_DEF,
  parameter int unsigned EXTENDED_MAX = tesp_pkg::EXTENDED_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tesp_in_if.sink     src_i,
  tesp_out_if.source  res_o
);
  import tesp_pkg::*;

  localparam int unsigned ECW = $clog2(EXTENDED_MAX + 1);

  logic                  phase_q, phase_d;
  logic [7:0]            name_bytes_q [NAME_CHARS];
  logic [7:0]            name_bytes_d [NAME_CHARS];
  logic [NAME_CNT_W-1:0] name_count_q, name_count_d;
  logic [CODE_W-1:0]     ext_chars_q [COLOUR_CHARS];
  logic [CODE_W-1:0]     ext_chars_d [COLOUR_CHARS];
  logic [ECW-1:0]        ext_count_q, ext_count_d;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q;
  result_t               res_d;

  logic                  in_fire;
  logic                  emit;
  logic [CODE_W-1:0]     c;

  // Accept while the result register is free or draining
  assign src_i.ready = !out_valid_q || res_o.ready;
  assign in_fire     = src_i.valid && src_i.ready;
  assign c           = src_i.code_unit;

  tesp_decode #(
    .NAME_CHARS(NAME_CHARS),
    .ECW       (ECW)
  ) u_decode (
    .name_bytes_i(name_bytes_q),
    .name_count_i(name_count_q),
    .ext_chars_i (ext_chars_q),
    .ext_count_i (ext_count_q),
    .has_ext_i   (phase_q),
    .result_o    (res_d)
  );

  // Advance the sequence state on each transfer
  always_comb begin
    phase_d      = phase_q;
    name_bytes_d = name_bytes_q;
    name_count_d = name_count_q;
    ext_chars_d  = ext_chars_q;
    ext_count_d  = ext_count_q;
    emit         = 1'b0;
    if (in_fire) begin
      if (!phase_q) begin
        if (c == CLOSE_BRACE) begin
          emit = 1'b1;
        end else if (c == COLON_CHAR) begin
          phase_d = 1'b1;
        end else begin
          for (int i = 0; i < NAME_CHARS; i++) begin
            if (name_count_q == NAME_CNT_W'(i)) begin
              name_bytes_d[i] = c[7:0];
            end
          end
          if (name_count_q != NAME_COUNT_MAX) begin
            name_count_d = name_count_q + NAME_CNT_W'(1);
          end
        end
      end else begin
        if (ext_count_q >= ECW'(EXTENDED_MAX) || c == CLOSE_BRACE) begin
          emit = 1'b1;
        end else begin
          for (int i = 0; i < COLOUR_CHARS; i++) begin
            if (ext_count_q == ECW'(i)) begin
              ext_chars_d[i] = c;
            end
          end
          ext_count_d = ext_count_q + ECW'(1);
        end
      end
      // Drop everything once the sequence has ended
      if (emit) begin
        phase_d      = 1'b0;
        name_bytes_d = '{default: '0};
        name_count_d = '0;
        ext_chars_d  = '{default: '0};
        ext_count_d  = '0;
      end
    end
  end

  // Hold a result until it is taken
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 1'b0;
      name_bytes_q <= '{default: '0};
      name_count_q <= '0;
      ext_chars_q  <= '{default: '0};
      ext_count_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      name_bytes_q <= name_bytes_d;
      name_count_q <= name_count_d;
      ext_chars_q  <= ext_chars_d;
      ext_count_q  <= ext_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Load the result payload at the end of a sequence
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = res_q.kind;
  assign res_o.red             = res_q.red;
  assign res_o.green           = res_q.green;
  assign res_o.blue            = res_q.blue;
  assign res_o.alpha           = res_q.alpha;
  assign res_o.span            = res_q.span;
  assign res_o.extended_length = res_q.extended_length;
  assign res_o.has_extended    = res_q.has_extended;

endmodule

// ===== rtl/tesp_checker.sv =====
`include "text_escape_sequence_parser_unit_assert.svh"

// Port-level checks on the parser.
module tesp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] kind_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i,
  input logic [8:0] span_i,
  input logic [3:0] extended_length_i,
  input logic       has_extended_i
);
  import tesp_pkg::*;

  logic [48:0] payload;
  logic        res_stall;
  logic        in_fire;
  logic        frame_ok;
  logic        alpha_clear;
  logic        colour_blank;

  // Gather the result fields and the conditions the checks look at
  assign payload      = {kind_i, red_i, green_i, blue_i, alpha_i, span_i,
                         extended_length_i, has_extended_i};
  assign res_stall    = out_valid_i && !out_ready_i;
  assign in_fire      = in_valid_i && in_ready_i;
  assign frame_ok     = (has_extended_i || extended_length_i == 4'd0) &&
                        span_i >= 9'd2 && kind_i <= KIND_UNKNOWN;
  assign alpha_clear  = out_valid_i && alpha_i != ALPHA_OPAQUE;
  assign colour_blank = alpha_i == 8'd0 && red_i == 8'd0 && green_i == 8'd0 &&
                        blue_i == 8'd0 && has_extended_i;

  // A stalled result holds its payload
  `TESP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_stall, out_valid_i && $stable(payload))

  // A new result follows an input transfer
  `TESP_ASSERT_IMPL(a_res_cause, clk_i, rst_ni, $rose(out_valid_i), $past(in_fire))

  // No extended characters without a colon, the span covers both braces, and the kind is valid
  `TESP_ASSERT_IMPL(a_ext_len, clk_i, rst_ni, out_valid_i, frame_ok)

  // Transparent alpha only with the marker, which blanks the colour
  `TESP_ASSERT_IMPL(a_alpha, clk_i, rst_ni, alpha_clear, colour_blank)

endmodule

bind text_escape_sequence_parser_unit tesp_checker u_tesp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (src_i.valid),
  .in_ready_i       (src_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .kind_i           (res_o.kind),
  .red_i            (res_o.red),
  .green_i          (res_o.green),
  .blue_i           (res_o.blue),
  .alpha_i          (res_o.alpha),
  .span_i           (res_o.span),
  .extended_length_i(res_o.extended_length),
  .has_extended_i   (res_o.has_extended)
);
